// ===== rtl/core/fdna_pkg.sv =====
// Shared types and constants for the frame downscaler with neighbor averaging.
// Used by the top level and by its output queue; depends on nothing.
package fdna_pkg;

    localparam int CFG_W   = 12;  // configuration register width
    localparam int CH_W    = 8;   // one color component
    localparam int PIX_W   = 24;  // packed red, green, blue
    localparam int COORD_W = 11;  // output row and column fields
    localparam int CNT_W   = 12;  // pixel and row counters
    localparam int ACC_W   = 24;  // running numerators and denominators
    localparam int SUM_W   = 10;  // sum of up to four components

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    localparam logic [CFG_W-1:0] RST_IN_WIDTH   = 12'd640;
    localparam logic [CFG_W-1:0] RST_IN_HEIGHT  = 12'd480;
    localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 12'd480;
    localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 12'd360;

    typedef enum logic [1:0] {
        CFG_IN_WIDTH   = 2'd0,
        CFG_IN_HEIGHT  = 2'd1,
        CFG_OUT_WIDTH  = 2'd2,
        CFG_OUT_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               last;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    red;
    } t_result;

endpackage

// ===== rtl/core/fdna_outq.sv =====
// Four-entry result queue between the averaging stage and the output port.
// Depends on fdna_pkg for the result type and the queue sizes.
module fdna_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fdna_pkg::t_result i_data,
    input  logic              i_inflight,
    input  logic              i_pop,
    output logic              o_valid,
    output fdna_pkg::t_result o_data,
    output logic              o_space
);
    import fdna_pkg::*;

    t_result              r_mem [0:OUTQ_DEPTH-1];
    logic [OUTQ_AW-1:0]   r_wr_ptr;
    logic [OUTQ_AW-1:0]   r_rd_ptr;
    logic [OUTQ_CW-1:0]   r_cnt;
    logic [OUTQ_CW-1:0]   n_cnt;
    logic                 w_pop;

    assign w_pop   = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Room is reserved for the request that is still in the averaging stage.
    assign o_space = (r_cnt + OUTQ_CW'(i_inflight)) <= OUTQ_CW'(OUTQ_DEPTH - 1);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/frame_downscale_neighbor_average.sv =====
// Top level of the frame downscaler with neighbor averaging.
// Depends on fdna_pkg and instantiates fdna_outq.
//
// Pixels enter in raster order at one pixel per clock and are never held back
// by the block itself; the only stall comes from a full result queue. Each
// output pixel (i,j) sits at the exact source position i*ih/oh, j*iw/ow and is
// the truncated average of the 1, 2 or 4 pixels at the floor and ceiling rows
// and columns of it. It can leave once the input pixel at its ceiling row and
// column is taken: the counters and the line store read finish at the accepting
// edge, the sum is formed in the averaging stage and is written straight into
// the result queue, where it is shown at the head. The previous row sits in a
// single-port line store of MAX_WIDTH entries that is read and written at the
// same address in the same clock, returning the old contents, so the registered
// read sets the averaging stage ahead of the result queue. Entries of the line
// store hold no defined value until the first full row has passed. tuser marks
// the first pixel of a frame; tlast marks the final output pixel of a frame.
module frame_downscale_neighbor_average #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    // Input pixels.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic        i_s_axis_tuser,  // frame_start
    // Output pixels.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // red_out, green_out, blue_out, out_row[34:24],
                                         // out_col[45:35], zero fill
    output logic        o_m_axis_tlast   // frame_last
);
    import fdna_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Configuration registers.
    logic [CFG_W-1:0] r_cfg_iw, r_cfg_ih, r_cfg_ow, r_cfg_oh;

    // Clamped dimensions.
    logic [CNT_W-1:0] w_iw, w_ih, w_ow, w_oh;

    // Frame position counters.
    logic [CNT_W-1:0] r_scol, r_srow, r_dcol, r_drow;
    logic [ACC_W-1:0] r_rnum, r_rden, r_cnum, r_cden;
    logic             r_rs, r_rp;
    logic [CNT_W-1:0] n_scol, n_srow, n_dcol, n_drow;
    logic [ACC_W-1:0] n_rnum, n_rden, n_cnum, n_cden;
    logic             n_rs, n_rp;

    // Counters as seen by the current request, after a frame start.
    logic [CNT_W-1:0] c_scol, c_srow, c_dcol, c_drow;
    logic [ACC_W-1:0] c_rnum, c_rden, c_cnum, c_cden;
    logic             w_rs, w_rp, w_emit, w_cp, w_last;
    logic             w_acc;
    logic [PIX_W-1:0] w_pix;

    // Line store and neighbors.
    logic [PIX_W-1:0] r_line [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] r_above;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_ul;
    logic [AW-1:0]    w_addr;

    // Averaging stage.
    logic               r_s1_valid;
    logic               r_s1_emit, r_s1_cp, r_s1_rp, r_s1_last;
    logic [PIX_W-1:0]   r_s1_pix, r_s1_left;
    logic [COORD_W-1:0] r_s1_row, r_s1_col;
    t_result            w_res;

    // Result queue.
    logic    w_q_valid, w_q_space;
    t_result w_q_data;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = w_q_space;
    assign w_acc           = i_s_axis_tvalid && w_q_space;
    assign w_pix           = i_s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_iw <= RST_IN_WIDTH;
            r_cfg_ih <= RST_IN_HEIGHT;
            r_cfg_ow <= RST_OUT_WIDTH;
            r_cfg_oh <= RST_OUT_HEIGHT;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IN_WIDTH:   r_cfg_iw <= i_cfg_data;
                CFG_IN_HEIGHT:  r_cfg_ih <= i_cfg_data;
                CFG_OUT_WIDTH:  r_cfg_ow <= i_cfg_data;
                CFG_OUT_HEIGHT: r_cfg_oh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input sizes are limited to MAX_WIDTH and MAX_HEIGHT, output sizes to the input.
    always_comb begin
        w_iw = (r_cfg_iw == '0) ? CNT_W'(1)
             : ((int'(r_cfg_iw) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : r_cfg_iw);
        w_ih = (r_cfg_ih == '0) ? CNT_W'(1)
             : ((int'(r_cfg_ih) > MAX_HEIGHT) ? CNT_W'(MAX_HEIGHT) : r_cfg_ih);
        w_ow = (r_cfg_ow == '0) ? CNT_W'(1) : ((r_cfg_ow > w_iw) ? w_iw : r_cfg_ow);
        w_oh = (r_cfg_oh == '0) ? CNT_W'(1) : ((r_cfg_oh > w_ih) ? w_ih : r_cfg_oh);
    end

    // A frame start takes the pixel as position zero of a new frame.
    always_comb begin
        c_scol = i_s_axis_tuser ? '0 : r_scol;
        c_srow = i_s_axis_tuser ? '0 : r_srow;
        c_dcol = i_s_axis_tuser ? '0 : r_dcol;
        c_drow = i_s_axis_tuser ? '0 : r_drow;
        c_rnum = i_s_axis_tuser ? '0 : r_rnum;
        c_rden = i_s_axis_tuser ? '0 : r_rden;
        c_cnum = i_s_axis_tuser ? '0 : r_cnum;
        c_cden = i_s_axis_tuser ? '0 : r_cden;
    end

    // The row choice is made on the first pixel of each row and then held.
    always_comb begin
        if (c_scol == '0) begin
            w_rs = (c_drow < w_oh) && (c_rden >= c_rnum)
                && ({1'b0, c_rden} < ({1'b0, c_rnum} + (ACC_W + 1)'(w_oh)));
            w_rp = (c_rden != c_rnum);
        end else begin
            w_rs = r_rs;
            w_rp = r_rp;
        end
        w_emit = w_rs && (c_dcol < w_ow) && (c_cden >= c_cnum)
              && ({1'b0, c_cden} < ({1'b0, c_cnum} + (ACC_W + 1)'(w_ow)));
        w_cp   = (c_cden != c_cnum);
        w_last = (c_drow == (w_oh - 1'b1)) && (c_dcol == (w_ow - 1'b1));
    end

    always_comb begin
        logic [CNT_W:0] scol_inc;
        logic [CNT_W:0] srow_inc;
        scol_inc = {1'b0, c_scol} + 1'b1;
        srow_inc = {1'b0, c_srow} + 1'b1;
        n_rs   = w_rs;
        n_rp   = w_rp;
        n_dcol = w_emit ? (c_dcol + 1'b1) : c_dcol;
        n_cnum = w_emit ? (c_cnum + ACC_W'(w_iw)) : c_cnum;
        n_scol = scol_inc[CNT_W-1:0];
        n_cden = c_cden + ACC_W'(w_ow);
        n_srow = c_srow;
        n_drow = c_drow;
        n_rnum = c_rnum;
        n_rden = c_rden;
        if (scol_inc >= {1'b0, w_iw}) begin
            n_scol = '0;
            n_cden = '0;
            n_dcol = '0;
            n_cnum = '0;
            if (w_rs) begin
                n_drow = c_drow + 1'b1;
                n_rnum = c_rnum + ACC_W'(w_ih);
            end
            n_srow = srow_inc[CNT_W-1:0];
            n_rden = c_rden + ACC_W'(w_oh);
            if (srow_inc >= {1'b0, w_ih}) begin
                n_srow = '0;
                n_drow = '0;
                n_rnum = '0;
                n_rden = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol <= '0;
            r_srow <= '0;
            r_dcol <= '0;
            r_drow <= '0;
            r_rnum <= '0;
            r_rden <= '0;
            r_cnum <= '0;
            r_cden <= '0;
            r_rs   <= 1'b0;
            r_rp   <= 1'b0;
            r_left <= '0;
        end else if (w_acc) begin
            r_scol <= n_scol;
            r_srow <= n_srow;
            r_dcol <= n_dcol;
            r_drow <= n_drow;
            r_rnum <= n_rnum;
            r_rden <= n_rden;
            r_cnum <= n_cnum;
            r_cden <= n_cden;
            r_rs   <= n_rs;
            r_rp   <= n_rp;
            r_left <= w_pix;
        end
    end

    // Read-first access: the request sees the row above, then replaces it.
    assign w_addr = AW'(c_scol);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_above        <= r_line[w_addr];
            r_line[w_addr] <= w_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_emit <= w_emit;
            r_s1_cp   <= w_cp;
            r_s1_rp   <= w_rp;
            r_s1_last <= w_last;
            r_s1_pix  <= w_pix;
            r_s1_left <= r_left;
            r_s1_row  <= c_drow[COORD_W-1:0];
            r_s1_col  <= c_dcol[COORD_W-1:0];
        end
    end

    // The upper-left neighbor is the row-above pixel of the previous request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul <= '0;
        end else if (r_s1_valid) begin
            r_ul <= r_above;
        end
    end

    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] avg;
        logic [CH_W-1:0]  chan [0:2];
        for (int ch = 0; ch < 3; ch++) begin
            sum = SUM_W'(r_s1_pix[ch*CH_W +: CH_W]);
            if (r_s1_cp) begin
                sum = sum + SUM_W'(r_s1_left[ch*CH_W +: CH_W]);
            end
            if (r_s1_rp) begin
                sum = sum + SUM_W'(r_above[ch*CH_W +: CH_W]);
            end
            if (r_s1_cp && r_s1_rp) begin
                sum = sum + SUM_W'(r_ul[ch*CH_W +: CH_W]);
            end
            avg = sum >> (SUM_W'(r_s1_cp) + SUM_W'(r_s1_rp));
            chan[ch] = avg[CH_W-1:0];
        end
        w_res.red   = chan[0];
        w_res.green = chan[1];
        w_res.blue  = chan[2];
        w_res.row   = r_s1_row;
        w_res.col   = r_s1_col;
        w_res.last  = r_s1_last;
    end

    fdna_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_s1_valid && r_s1_emit),
        .i_data     (w_res),
        .i_inflight (r_s1_valid),
        .i_pop      (i_m_axis_tready),
        .o_valid    (w_q_valid),
        .o_data     (w_q_data),
        .o_space    (w_q_space)
    );

    assign o_m_axis_tvalid = w_q_valid;
    assign o_m_axis_tlast  = w_q_data.last;
    assign o_m_axis_tdata  = {2'b00, w_q_data.col, w_q_data.row,
                              w_q_data.blue, w_q_data.green, w_q_data.red};

endmodule

// ===== rtl/core/fdna_checker.sv =====
// Port-level checks for the frame downscaler, bound to its top level.
// Depends only on the top level's ports.
module fdna_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_cfg_ready,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

    // The queue is empty after reset, so no result and full input readiness.
    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready right after reset");

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind frame_downscale_neighbor_average fdna_checker u_fdna_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_cfg_ready     (o_cfg_ready),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
